/* sv/pow2_free_list_allocator_assert.svh */
// ----------------------------------------------------------------------------
// pow2_free_list_allocator_assert.svh
// assertion macros of the allocator checker
// ----------------------------------------------------------------------------
`ifndef POW2_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define POW2_FREE_LIST_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PFLA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pfla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_pkg
// types and constants of the power-of-two free list allocator
// ----------------------------------------------------------------------------
package pfla_pkg;

	localparam int ADDR_W    = 16;
	localparam int SIZE_W    = 17;
	localparam int ALU_W     = SIZE_W + 1;
	localparam int CLS_W     = 5;
	localparam int MIN_CLASS = 3;
	localparam int MAX_CLASS = 17;

	// pointer alignment less one, and the smallest block
	localparam logic [ALU_W-1:0] ALIGN_LSBS = ALU_W'(7);
	localparam logic [ALU_W-1:0] MIN_SIZE   = ALU_W'(8);

	localparam logic [SIZE_W-1:0] HEAP_LIMIT_RESET = SIZE_W'(65536);

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             lt;
	} alu_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROUND,
		ST_CLASS,
		ST_DISPATCH,
		ST_POP_RD,
		ST_POP_WR,
		ST_BUMP,
		ST_CHECK,
		ST_FREE,
		ST_TOTAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t              command;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted_address;
		logic [SIZE_W-1:0] granted_size;
		logic              out_of_memory;
		logic [SIZE_W-1:0] bytes_in_use;
	} rsp_t;

endpackage

/* sv/pfla_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* sv/pfla_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_alu
// shared add / subtract-compare unit of the allocator sequencer
// ----------------------------------------------------------------------------
module pfla_alu (
	input  pfla_pkg::alu_op_t             op,
	input  logic [pfla_pkg::ALU_W-1:0]    a,
	input  logic [pfla_pkg::ALU_W-1:0]    b,
	output pfla_pkg::alu_res_t            res
);
	import pfla_pkg::*;

	logic [ALU_W:0]   full;
	logic [ALU_W-1:0] b_in;

	always_comb begin
		b_in = (op == ALU_SUB) ? ~b : b;
		full = {1'b0, a} + {1'b0, b_in} + {{ALU_W{1'b0}}, (op == ALU_SUB)};
		res.sum = full[ALU_W-1:0];
		// no carry out of a subtract means a borrow, so a < b
		res.lt  = (op == ALU_SUB) && !full[ALU_W];
	end

endmodule

/* sv/pow2_free_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow2_free_list_allocator
// power-of-two segregated free list heap allocator
// ----------------------------------------------------------------------------
// Each transaction on req is an allocate or a free; each gives exactly one
// transaction on rsp. Sizes round up to a multiple of 8 and then to a power of
// two 2^c (zero counts as 8). Allocate pops the LIFO list of class c, or bumps
// the top of heap if that list is empty, and flags out_of_memory when
// top + size would reach min(heap_limit, HEAP_BYTES). Free pushes the block
// and lowers bytes_in_use, saturating at zero. One item is worked at a time by
// a sequencer around a single shared adder/comparator; the class search takes
// one compare per doubling, and c runs from 3 to 17. A new item is taken only
// once the result of the last is loaded into the output register. Free-list
// links live in a ram of HEAP_BYTES / 8 entries (at most 8192) indexed by
// address bits above bit 2; HEAP_BYTES is taken as a power of two. Popping a
// link that was never pushed returns an undefined block. heap_limit is to be
// written through cfg only while no item is in flight; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module pow2_free_list_allocator #(
	parameter int HEAP_BYTES  = 65536,
	parameter int CLASS_COUNT = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  pfla_pkg::req_t                req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output pfla_pkg::rsp_t                rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfla_pkg::SIZE_W-1:0]   cfg_data
);
	import pfla_pkg::*;

	localparam int LINK_MAX   = 1 << (ADDR_W - 3);
	localparam int LINK_DEPTH = (HEAP_BYTES / 8 < LINK_MAX) ? HEAP_BYTES / 8 : LINK_MAX;
	localparam int LINK_AW    = $clog2(LINK_DEPTH);
	localparam int HEAD_N     = (CLASS_COUNT < MAX_CLASS + 1) ? CLASS_COUNT : MAX_CLASS + 1;
	localparam int HEAD_IW    = $clog2(HEAD_N);
	localparam logic [SIZE_W-1:0] LIMIT_CAP =
		(HEAP_BYTES > (1 << SIZE_W) - 1) ? {SIZE_W{1'b1}} : SIZE_W'(HEAP_BYTES);
	localparam logic [SIZE_W-1:0] LIMIT_RESET =
		(LIMIT_CAP < HEAP_LIMIT_RESET) ? LIMIT_CAP : HEAP_LIMIT_RESET;

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [SIZE_W-1:0] req_size_q;
	logic [ADDR_W-1:0] baddr_q;
	logic [ALU_W-1:0]  s8_q;
	logic [ALU_W-1:0]  p_q;
	logic [CLS_W-1:0]  cls_q;
	logic [ALU_W-1:0]  sum_q;
	logic [ADDR_W-1:0] addr_q;
	logic              oom_q;

	logic [ADDR_W-1:0] head_q [HEAD_N];
	logic [HEAD_N-1:0] hvalid_q;
	logic [SIZE_W-1:0] top_q;
	logic [SIZE_W-1:0] total_q;
	logic [SIZE_W-1:0] limit_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	alu_op_t          alu_op;
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	alu_res_t         alu_res;

	logic                ram_we;
	logic [LINK_AW-1:0]  ram_waddr;
	logic [LINK_AW-1:0]  ram_raddr;
	logic [ADDR_W:0]     ram_wdata;
	logic [ADDR_W:0]     ram_rdata;

	logic [HEAD_IW-1:0] cls_idx;
	logic               oversize;
	logic               rsp_load;

	assign cls_idx   = HEAD_IW'(cls_q);
	assign oversize  = int'(cls_q) >= CLASS_COUNT;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// link entry: valid of the next block in the list, then its address
	assign ram_waddr = LINK_AW'(baddr_q >> 3);
	assign ram_raddr = LINK_AW'(head_q[cls_idx] >> 3);
	assign ram_wdata = {hvalid_q[cls_idx], head_q[cls_idx]};

	pfla_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	pfla_ram #(
		.WIDTH (ADDR_W + 1),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND:    state_d = ST_CLASS;
			ST_CLASS: begin
				if (!alu_res.lt) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (oversize) begin
					state_d = ST_DONE;
				end else if (cmd_q == CMD_FREE) begin
					state_d = ST_FREE;
				end else if (hvalid_q[cls_idx]) begin
					state_d = ST_POP_RD;
				end else begin
					state_d = ST_BUMP;
				end
			end
			ST_POP_RD:   state_d = ST_POP_WR;
			ST_POP_WR:   state_d = ST_TOTAL;
			ST_BUMP:     state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = alu_res.lt ? ST_TOTAL : ST_DONE;
			end
			ST_FREE:     state_d = ST_TOTAL;
			ST_TOTAL:    state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		alu_op    = ALU_ADD;
		alu_a     = '0;
		alu_b     = '0;
		ram_we    = 1'b0;
		case (state_q)
			ST_ROUND: begin
				alu_a = {1'b0, req_size_q};
				alu_b = ALIGN_LSBS;
			end
			ST_CLASS: begin
				alu_op = ALU_SUB;
				alu_a  = p_q;
				alu_b  = s8_q;
			end
			ST_BUMP: begin
				alu_a = {1'b0, top_q};
				alu_b = p_q;
			end
			ST_CHECK: begin
				alu_op = ALU_SUB;
				alu_a  = sum_q;
				alu_b  = {1'b0, limit_q};
			end
			ST_FREE: begin
				ram_we = 1'b1;
			end
			ST_TOTAL: begin
				alu_op = (cmd_q == CMD_FREE) ? ALU_SUB : ALU_ADD;
				alu_a  = {1'b0, total_q};
				alu_b  = p_q;
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_RESET;
			top_q       <= '0;
			total_q     <= '0;
			hvalid_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= (cfg_data > LIMIT_CAP) ? LIMIT_CAP : cfg_data;
			end
			if (state_q == ST_CHECK && alu_res.lt) begin
				top_q <= sum_q[SIZE_W-1:0];
			end
			if (state_q == ST_TOTAL) begin
				if (cmd_q == CMD_FREE) begin
					total_q <= alu_res.lt ? '0 : alu_res.sum[SIZE_W-1:0];
				end else begin
					total_q <= alu_res.sum[SIZE_W] ? {SIZE_W{1'b1}} : alu_res.sum[SIZE_W-1:0];
				end
			end
			if (state_q == ST_FREE) begin
				hvalid_q[cls_idx] <= 1'b1;
			end else if (state_q == ST_POP_WR) begin
				hvalid_q[cls_idx] <= ram_rdata[ADDR_W];
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd_q      <= req_data.command;
					req_size_q <= req_data.request_size;
					baddr_q    <= req_data.block_address;
					addr_q     <= '0;
					oom_q      <= 1'b0;
				end
			end
			ST_ROUND: begin
				s8_q  <= alu_res.sum & ~ALIGN_LSBS;
				p_q   <= MIN_SIZE;
				cls_q <= CLS_W'(MIN_CLASS);
			end
			ST_CLASS: begin
				if (alu_res.lt) begin
					p_q   <= p_q << 1;
					cls_q <= cls_q + CLS_W'(1);
				end
			end
			ST_DISPATCH: begin
				if (oversize) begin
					oom_q <= (cmd_q == CMD_ALLOC);
				end
			end
			ST_POP_RD: begin
				addr_q <= head_q[cls_idx];
			end
			ST_POP_WR: begin
				head_q[cls_idx] <= ram_rdata[ADDR_W-1:0];
			end
			ST_BUMP: begin
				sum_q <= alu_res.sum;
			end
			ST_CHECK: begin
				if (alu_res.lt) begin
					addr_q <= top_q[ADDR_W-1:0];
				end else begin
					oom_q <= 1'b1;
				end
			end
			ST_FREE: begin
				head_q[cls_idx] <= baddr_q;
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.granted_address <= addr_q;
			rsp_q.granted_size    <= oversize ? '0 : p_q[SIZE_W-1:0];
			rsp_q.out_of_memory   <= oom_q;
			rsp_q.bytes_in_use    <= total_q;
		end
	end

endmodule

/* sv/pfla_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "pow2_free_list_allocator_assert.svh"

module pfla_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input pfla_pkg::rsp_t rsp_data
);
	import pfla_pkg::*;

	// a result offered but stalled stays offered and unchanged
	`PFLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

	// one transaction at a time: busy right after an accept
	`PFLA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request taken while busy")

	// a failed allocate grants no address
	`PFLA_ASSERT_NOW(a_oom_no_addr, rsp_valid && rsp_data.out_of_memory, rsp_data.granted_address == '0, "address granted on out of memory")

	// granted size is zero or a power of two of at least eight
	`PFLA_ASSERT_NOW(a_size_pow2, rsp_valid, ($countones(rsp_data.granted_size) <= 1) && (rsp_data.granted_size[2:0] == 3'b000), "granted size not a power of two")

endmodule

bind pow2_free_list_allocator pfla_checker u_pfla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
